FILE: hdl/hvt_pkg.sv
// Shared constants for the homogeneous vertex transform block.
// Used by hvt_div_lane and homogeneous_vertex_transform_top; depends on nothing.
`timescale 1ns / 1ps

package hvt_pkg;

   // Field and register geometry.
   localparam int COORD_W  = 32;
   localparam int REG_W    = 64;
   localparam int NUM_REGS = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int NUM_ROWS = 4;
   localparam int NUM_LANES = 3;

   // Quotient magnitude bits produced by the divider, one per compare stage.
   localparam int QUOT_W = 32;

   // Configuration register indexes.
   localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

   // Clamp limits of a 32-bit signed result.
   localparam logic [COORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

endpackage

FILE: hdl/hvt_div_lane.sv
// Pipelined restoring divider lane: an entry stage, then one quotient bit per compare stage.
// Depends on hvt_pkg for the quotient width.
`timescale 1ns / 1ps

module hvt_div_lane #(
   parameter int NUM_W = 66,
   parameter int DEN_W = 50
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [hvt_pkg::QUOT_W-1:0] quot,
   output logic             ovf
);

   localparam int QW    = hvt_pkg::QUOT_W;
   localparam int HI_W  = NUM_W - QW;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int DEPTH = QW + 1;

   logic [DEN_W-1:0] rem_ff [DEPTH];
   logic [QW-1:0]    low_ff [DEPTH];
   logic [QW-1:0]    q_ff   [DEPTH];
   logic [DEN_W-1:0] den_ff [DEPTH];
   logic             ovf_ff [DEPTH];

   logic [HI_W-1:0]  hi;
   logic             hi_ovf;

   // The quotient overflows 32 bits exactly when the upper part reaches the divisor.
   assign hi     = num[NUM_W-1:QW];
   assign hi_ovf = CMP_W'(hi) >= CMP_W'(den);

   // Entry stage: start the partial remainder from the upper numerator bits.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= hi_ovf ? '0 : DEN_W'(hi);
         low_ff[0] <= num[QW-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= hi_ovf;
      end
   end

   // One compare and subtract per stage.
   for (genvar k = 1; k < DEPTH; k++) begin : g_step
      logic [DEN_W:0] r2;
      logic           ge;

      assign r2 = {rem_ff[k-1], low_ff[k-1][QW-1]};
      assign ge = r2 >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? DEN_W'(r2 - {1'b0, den_ff[k-1]}) : DEN_W'(r2);
            low_ff[k] <= {low_ff[k-1][QW-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = q_ff[DEPTH-1];
   assign ovf  = ovf_ff[DEPTH-1];

endmodule

FILE: hdl/homogeneous_vertex_transform_top.sv
// Homogeneous 4x4 vertex transform with perspective divide, top level.
// Depends on hvt_pkg and hvt_div_lane.
`timescale 1ns / 1ps
//
//  Channel  Dir  Handshake              Payload
//  req_     in   req_tvalid/req_tready  tdata = in_x, in_y, in_z
//  rsp_     out  rsp_tvalid/rsp_tready  tdata = out_x, out_y, out_z;
//                                       tuser = w_was_zero, saturated
//  csr_     in   csr_wen                csr_addr, csr_wdata
//
// One beat is accepted every cycle while the output side takes results.
// Registered steps: multiply, row sum, sign split, 33 divider stages
// (an overflow check, then one quotient bit each) and the output register.
// Reset (synchronous, active high) loads the identity matrix and empties the pipe.
// A stalled output register holds the whole pipe; nothing is dropped or repeated.

module homogeneous_vertex_transform_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
   output logic [1:0]  rsp_tuser,   // w_was_zero [0], saturated [1]
   input  logic        csr_wen,
   input  logic [hvt_pkg::REG_IDX_W-1:0] csr_addr,
   input  logic [hvt_pkg::REG_W-1:0]     csr_wdata
);

   localparam int CW    = hvt_pkg::COORD_W;
   localparam int PW    = 2 * CW;
   localparam int AW    = PW + 2;
   localparam int SW    = AW - FRAC_BITS;
   localparam int NW    = SW + FRAC_BITS;
   localparam int NR    = hvt_pkg::NUM_ROWS;
   localparam int NL    = hvt_pkg::NUM_LANES;
   localparam int DEPTH = hvt_pkg::QUOT_W + 1;
   localparam logic [hvt_pkg::REG_W-1:0] ONE = hvt_pkg::REG_W'(1) << FRAC_BITS;

   // Matrix registers.
   logic [hvt_pkg::REG_W-1:0] mat_ff [hvt_pkg::NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[hvt_pkg::REG_ROW0_COLS01] <= ONE;
         mat_ff[hvt_pkg::REG_ROW0_COLS23] <= '0;
         mat_ff[hvt_pkg::REG_ROW1_COLS01] <= ONE << CW;
         mat_ff[hvt_pkg::REG_ROW1_COLS23] <= '0;
         mat_ff[hvt_pkg::REG_ROW2_COLS01] <= '0;
         mat_ff[hvt_pkg::REG_ROW2_COLS23] <= ONE;
         mat_ff[hvt_pkg::REG_ROW3_COLS01] <= '0;
         mat_ff[hvt_pkg::REG_ROW3_COLS23] <= ONE << CW;
      end else if (csr_wen) begin
         mat_ff[csr_addr] <= csr_wdata;
      end
   end

   // Split registers into signed entries.
   logic signed [CW-1:0] ent [NR][4];
   always_comb begin
      for (int r = 0; r < NR; r++) begin
         ent[r][0] = mat_ff[2*r][CW-1:0];
         ent[r][1] = mat_ff[2*r][2*CW-1:CW];
         ent[r][2] = mat_ff[2*r+1][CW-1:0];
         ent[r][3] = mat_ff[2*r+1][2*CW-1:CW];
      end
   end

   // Whole pipe advances unless the output register holds an untaken result.
   logic rsp_valid_ff;
   logic adv;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: twelve products.
   logic signed [CW-1:0] vin [NL];
   logic signed [PW-1:0] prod_ff  [NR][NL];
   logic signed [CW-1:0] trans_ff [NR];
   logic                 v1_ff;

   always_comb begin
      for (int c = 0; c < NL; c++) vin[c] = req_tdata[c*CW +: CW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < NR; r++) begin
            for (int c = 0; c < NL; c++) prod_ff[r][c] <= ent[r][c] * vin[c];
            trans_ff[r] <= ent[r][3];
         end
      end
   end

   // Stage 2: exact row sums with the translation aligned to the product scale.
   logic signed [AW-1:0] sum_ff [NR];
   logic                 v2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < NR; r++) begin
            sum_ff[r] <= AW'(prod_ff[r][0]) + AW'(prod_ff[r][1]) + AW'(prod_ff[r][2])
                         + (AW'(trans_ff[r]) <<< FRAC_BITS);
         end
      end
   end

   // Stage 3: floor to the output scale, then split sign and magnitude.
   logic signed [AW-1:0] sh   [NR];
   logic signed [SW-1:0] srow [NR];
   logic [SW-1:0]        num_ff [NL];
   logic [SW-1:0]        den_ff;
   logic [NL-1:0]        neg_ff;
   logic signed [SW-1:0] raw_ff [NL];
   logic                 wz_ff;
   logic                 v3_ff;

   always_comb begin
      for (int r = 0; r < NR; r++) begin
         sh[r]   = sum_ff[r] >>> FRAC_BITS;
         srow[r] = sh[r][SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < NL; r++) begin
            num_ff[r] <= srow[r][SW-1] ? SW'(-srow[r]) : SW'(srow[r]);
            neg_ff[r] <= srow[r][SW-1] ^ srow[NR-1][SW-1];
            raw_ff[r] <= srow[r];
         end
         den_ff <= srow[NR-1][SW-1] ? SW'(-srow[NR-1]) : SW'(srow[NR-1]);
         wz_ff  <= (srow[NR-1] == '0);
      end
   end

   // Divider lanes.
   logic [hvt_pkg::QUOT_W-1:0] quot [NL];
   logic [NL-1:0]              qovf;

   for (genvar l = 0; l < NL; l++) begin : g_lane
      hvt_div_lane #(
         .NUM_W (NW),
         .DEN_W (SW)
      ) u_lane (
         .clock (clock),
         .en    (adv),
         .num   ({num_ff[l], {FRAC_BITS{1'b0}}}),
         .den   (den_ff),
         .quot  (quot[l]),
         .ovf   (qovf[l])
      );
   end

   // Sideband that travels beside the divider stages.
   logic                 sb_v_ff   [DEPTH];
   logic                 sb_wz_ff  [DEPTH];
   logic [NL-1:0]        sb_neg_ff [DEPTH];
   logic signed [SW-1:0] sb_raw_ff [DEPTH][NL];

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_wz_ff[0]  <= wz_ff;
         sb_neg_ff[0] <= neg_ff;
         for (int r = 0; r < NL; r++) sb_raw_ff[0][r] <= raw_ff[r];
         for (int k = 1; k < DEPTH; k++) begin
            sb_wz_ff[k]  <= sb_wz_ff[k-1];
            sb_neg_ff[k] <= sb_neg_ff[k-1];
            for (int r = 0; r < NL; r++) sb_raw_ff[k][r] <= sb_raw_ff[k-1][r];
         end
      end
   end

   // Valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k < DEPTH; k++) sb_v_ff[k] <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         sb_v_ff[0] <= v3_ff;
         for (int k = 1; k < DEPTH; k++) sb_v_ff[k] <= sb_v_ff[k-1];
      end
   end

   // Final clamp and sign restore.
   logic [CW-1:0] res  [NL];
   logic [NL-1:0] lsat;
   logic          sgn;
   logic [SW-1:0] rw;

   always_comb begin
      for (int r = 0; r < NL; r++) begin
         rw  = sb_raw_ff[DEPTH-1][r];
         sgn = sb_neg_ff[DEPTH-1][r];
         if (sb_wz_ff[DEPTH-1]) begin
            lsat[r] = !((rw[SW-1:CW-1] == '0) || (rw[SW-1:CW-1] == '1));
            if (lsat[r]) res[r] = rw[SW-1] ? hvt_pkg::NEG_LIMIT : hvt_pkg::POS_LIMIT;
            else         res[r] = rw[CW-1:0];
         end else if (sgn) begin
            lsat[r] = qovf[r] || (quot[r][CW-1] && (quot[r][CW-2:0] != '0));
            res[r]  = lsat[r] ? hvt_pkg::NEG_LIMIT : CW'(-quot[r]);
         end else begin
            lsat[r] = qovf[r] || quot[r][CW-1];
            res[r]  = lsat[r] ? hvt_pkg::POS_LIMIT : quot[r];
         end
      end
   end

   // Output register.
   logic [95:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sb_v_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {res[2], res[1], res[0]};
         rsp_user_ff <= {|lsat, sb_wz_ff[DEPTH-1]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A nonzero w must reach the divider as a nonzero divisor.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !wz_ff) |-> (den_ff != '0))
      else $error("divisor is zero while w is flagged nonzero");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stall freezes the valid bits of stages 1 to 3.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(v3_ff) && $stable(v1_ff) && $stable(v2_ff)))
      else $error("pipe moved during a stall");

endmodule
